// ----- src/crfe_pkg.sv -----
// Package: shared constants, opcodes and controller/datapath interface types.
`timescale 1ns / 1ps
package crfe_pkg;

   localparam int DEF_MAX_WIDTH  = 320;
   localparam int DEF_MAX_HEIGHT = 240;

   localparam int OP_W     = 2;
   localparam int COORD_W  = 16;
   localparam int PIXEL_W  = 16;
   localparam int CHAN_W   = 8;
   localparam int SURF_W_W = 9;
   localparam int SURF_H_W = 8;
   localparam int CALC_W   = 18;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] REG_SURFACE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SURFACE_HEIGHT = 2'd1;

   localparam logic [SURF_W_W-1:0] SURFACE_WIDTH_RESET  = 9'd320;
   localparam logic [SURF_H_W-1:0] SURFACE_HEIGHT_RESET = 8'd240;

   localparam logic [OP_W-1:0] OP_FILL_SCREEN  = 2'd0;
   localparam logic [OP_W-1:0] OP_FILL_RECT    = 2'd1;
   localparam logic [OP_W-1:0] OP_OUTLINE_RECT = 2'd2;
   localparam logic [OP_W-1:0] OP_READ_PIXEL   = 2'd3;

   localparam logic [1:0] SEG_LAST = 2'd3;

   typedef struct packed {
      logic       load;
      logic       seg_calc;
      logic       clip_calc;
      logic       start_iter;
      logic       paint;
      logic       clear;
      logic       read;
      logic       resp;
      logic [1:0] seg;
   } crfe_cmd_type;

   typedef struct packed {
      logic            empty;
      logic [OP_W-1:0] op;
      logic            last_pixel;
      logic            clear_done;
   } crfe_stat_type;

endpackage

// ----- src/crfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module crfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/crfe_ctrl.sv -----
// Controller: command sequencing, segment stepping and post-reset clearing pass.
`timescale 1ns / 1ps
module crfe_ctrl
   import crfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output crfe_cmd_type  cmd,
   input  crfe_stat_type stat
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_SEG   = 4'd2;
   localparam logic [3:0] S_CLIP  = 4'd3;
   localparam logic [3:0] S_START = 4'd4;
   localparam logic [3:0] S_PAINT = 4'd5;
   localparam logic [3:0] S_NEXT  = 4'd6;
   localparam logic [3:0] S_RREAD = 4'd7;
   localparam logic [3:0] S_RDATA = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] seg_ff, seg_in;

   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      cmd      = '0;
      cmd.seg  = seg_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               seg_in   = 2'd0;
               state_in = S_SEG;
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_SEG: begin
            cmd.seg_calc = 1'b1;
            state_in     = S_CLIP;
         end
         S_CLIP: begin
            cmd.clip_calc = 1'b1;
            state_in      = S_START;
         end
         S_START: begin
            cmd.start_iter = 1'b1;
            if (stat.op == OP_READ_PIXEL) begin
               state_in = S_RREAD;
            end else if (stat.empty) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_PAINT;
            end
         end
         S_PAINT: begin
            cmd.paint = 1'b1;
            if (stat.last_pixel) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (stat.op == OP_OUTLINE_RECT && seg_ff != SEG_LAST) begin
               seg_in   = seg_ff + 2'd1;
               state_in = S_SEG;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RREAD: begin
            cmd.read = 1'b1;
            state_in = S_RDATA;
         end
         S_RDATA: begin
            cmd.resp = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         seg_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_paint_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAINT) |-> !stat.empty)
      else $error("painting an empty clipped range");

   a_seg_outline_only: assert property (@(posedge clock) disable iff (reset)
      (seg_ff != 2'd0) |-> (stat.op == OP_OUTLINE_RECT))
      else $error("segment step outside outline command");

   a_read_then_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RREAD) |=> (state_ff == S_RDATA))
      else $error("read not followed by response cycle");
`endif

endmodule

// ----- src/crfe_dp.sv -----
// Datapath: command registers, clipping, pixel address walk, frame store and result.
`timescale 1ns / 1ps
module crfe_dp
   import crfe_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  crfe_cmd_type              cmd,
   output crfe_stat_type             stat,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_rect_width,
   input  logic signed [COORD_W-1:0] req_rect_height,
   input  logic [PIXEL_W-1:0]        req_color,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wr_data,
   output logic                      rsp_strobe,
   output logic [PIXEL_W-1:0]        rsp_pixel_word,
   output logic [CHAN_W-1:0]         rsp_red8,
   output logic [CHAN_W-1:0]         rsp_green8,
   output logic [CHAN_W-1:0]         rsp_blue8,
   output logic                      rsp_in_range
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam logic signed [CALC_W-1:0] ONE    = CALC_W'(1);
   localparam logic signed [CALC_W-1:0] ZERO   = CALC_W'(0);
   localparam logic signed [CALC_W-1:0] MAXW_S = CALC_W'(MAX_WIDTH);
   localparam logic signed [CALC_W-1:0] MAXH_S = CALC_W'(MAX_HEIGHT);
   localparam logic [AW-1:0]            STRIDE = AW'(MAX_WIDTH);
   localparam logic [AW-1:0]            LAST_ADDR = AW'(DEPTH - 1);

   logic [SURF_W_W-1:0] surf_w_ff;
   logic [SURF_H_W-1:0] surf_h_ff;

   logic [OP_W-1:0]           op_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff, w_ff, h_ff;
   logic [PIXEL_W-1:0]        color_ff;

   logic signed [CALC_W-1:0] xe, ye, we, he, swe, she;
   logic signed [CALC_W-1:0] seg_x_in, seg_y_in, seg_w_in, seg_h_in;
   logic signed [CALC_W-1:0] seg_x_ff, seg_y_ff, seg_w_ff, seg_h_ff;
   logic signed [CALC_W-1:0] act_w_ff, act_h_ff;
   logic signed [CALC_W-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [CALC_W-1:0] x_sum, y_sum, x1_m, y1_m;

   logic          outline_bad, nonempty;
   logic          ok_ff;
   logic [XW-1:0] xx_ff, x_start_ff, x_end_ff;
   logic [YW-1:0] yy_ff, y_end_ff;
   logic [AW-1:0] row_base_ff, pix_addr, clr_addr_ff;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr;
   logic [PIXEL_W-1:0] ram_wdata, ram_rdata;

   logic               rsp_valid_ff;
   logic [PIXEL_W-1:0] pixel_ff;
   logic               in_range_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         surf_w_ff <= SURFACE_WIDTH_RESET;
         surf_h_ff <= SURFACE_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_SURFACE_WIDTH:  surf_w_ff <= csr_wr_data[SURF_W_W-1:0];
            REG_SURFACE_HEIGHT: surf_h_ff <= csr_wr_data[SURF_H_W-1:0];
            default: ;
         endcase
      end
   end

   // command capture on transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         w_ff     <= req_rect_width;
         h_ff     <= req_rect_height;
         color_ff <= req_color;
      end
   end

   assign xe  = CALC_W'(x_ff);
   assign ye  = CALC_W'(y_ff);
   assign we  = CALC_W'(w_ff);
   assign he  = CALC_W'(h_ff);
   assign swe = CALC_W'(surf_w_ff);
   assign she = CALC_W'(surf_h_ff);

   always_comb begin
      seg_x_in = xe;
      seg_y_in = ye;
      seg_w_in = ONE;
      seg_h_in = ONE;
      case (op_ff)
         OP_FILL_SCREEN: begin
            seg_x_in = ZERO;
            seg_y_in = ZERO;
            seg_w_in = swe;
            seg_h_in = she;
         end
         OP_FILL_RECT: begin
            seg_w_in = we;
            seg_h_in = he;
         end
         OP_OUTLINE_RECT: begin
            case (cmd.seg)
               2'd0: seg_w_in = we;
               2'd1: begin
                  seg_y_in = ye + he - ONE;
                  seg_w_in = we;
               end
               2'd2: seg_h_in = he;
               default: begin
                  seg_x_in = xe + we - ONE;
                  seg_h_in = he;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.seg_calc) begin
         seg_x_ff <= seg_x_in;
         seg_y_ff <= seg_y_in;
         seg_w_ff <= seg_w_in;
         seg_h_ff <= seg_h_in;
         act_w_ff <= (swe < MAXW_S) ? swe : MAXW_S;
         act_h_ff <= (she < MAXH_S) ? she : MAXH_S;
      end
   end

   assign x_sum = seg_x_ff + seg_w_ff;
   assign y_sum = seg_y_ff + seg_h_ff;

   always_ff @(posedge clock) begin
      if (cmd.clip_calc) begin
         x0_ff <= (seg_x_ff > ZERO) ? seg_x_ff : ZERO;
         y0_ff <= (seg_y_ff > ZERO) ? seg_y_ff : ZERO;
         x1_ff <= (x_sum < act_w_ff) ? x_sum : act_w_ff;
         y1_ff <= (y_sum < act_h_ff) ? y_sum : act_h_ff;
      end
   end

   assign outline_bad = (op_ff == OP_OUTLINE_RECT) && ((w_ff <= 0) || (h_ff <= 0));
   assign nonempty    = (x0_ff < x1_ff) && (y0_ff < y1_ff) && !outline_bad;
   assign x1_m        = x1_ff - ONE;
   assign y1_m        = y1_ff - ONE;
   assign pix_addr    = row_base_ff + AW'(xx_ff);

   // clipped range walk, one pixel a cycle
   always_ff @(posedge clock) begin
      if (cmd.start_iter) begin
         ok_ff       <= nonempty;
         x_start_ff  <= x0_ff[XW-1:0];
         x_end_ff    <= x1_m[XW-1:0];
         y_end_ff    <= y1_m[YW-1:0];
         xx_ff       <= x0_ff[XW-1:0];
         yy_ff       <= y0_ff[YW-1:0];
         row_base_ff <= AW'(y0_ff[YW-1:0]) * STRIDE;
      end else if (cmd.paint) begin
         if (xx_ff == x_end_ff) begin
            xx_ff       <= x_start_ff;
            yy_ff       <= yy_ff + YW'(1);
            row_base_ff <= row_base_ff + STRIDE;
         end else begin
            xx_ff <= xx_ff + XW'(1);
         end
      end
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   assign ram_we    = cmd.paint || cmd.clear;
   assign ram_waddr = cmd.clear ? clr_addr_ff : pix_addr;
   assign ram_wdata = cmd.clear ? '0 : color_ff;
   assign ram_re    = cmd.read && ok_ff;

   crfe_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (pix_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.resp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp) begin
         pixel_ff    <= ok_ff ? ram_rdata : '0;
         in_range_ff <= ok_ff;
      end
   end

   assign stat.empty      = !nonempty;
   assign stat.op         = op_ff;
   assign stat.last_pixel = (xx_ff == x_end_ff) && (yy_ff == y_end_ff);
   assign stat.clear_done = (clr_addr_ff == LAST_ADDR);

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_pixel_word = pixel_ff;
   assign rsp_red8       = {pixel_ff[15:11], pixel_ff[15:13]};
   assign rsp_green8     = {pixel_ff[10:5], pixel_ff[10:9]};
   assign rsp_blue8      = {pixel_ff[4:0], pixel_ff[4:2]};
   assign rsp_in_range   = in_range_ff;

endmodule

// ----- src/clipped_rect_fill_engine_unit.sv -----
// Rectangle fill engine over an RGB565 frame store: pixel walk one write per cycle.
// Read pixel: busy in seg/clip/start/read/response; result strobes as busy drops.
// Fill screen/rect: seg/clip/start, one write per clipped pixel (single write port).
// Outline rect: 4 segments, each as above; a new command follows once busy drops.
// Reset (synchronous, high) runs a clearing pass of all MAX_WIDTH*MAX_HEIGHT words,
// busy high meanwhile; csr writes are taken. The receiver cannot stall.
`timescale 1ns / 1ps
module clipped_rect_fill_engine_unit
   import crfe_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_rect_width,
   input  logic signed [COORD_W-1:0] req_rect_height,
   input  logic [PIXEL_W-1:0]        req_color,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wr_data,
   output logic                      rsp_strobe,
   output logic [PIXEL_W-1:0]        rsp_pixel_word,
   output logic [CHAN_W-1:0]         rsp_red8,
   output logic [CHAN_W-1:0]         rsp_green8,
   output logic [CHAN_W-1:0]         rsp_blue8,
   output logic                      rsp_in_range
);

   crfe_cmd_type  cmd;
   crfe_stat_type stat;

   crfe_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   crfe_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_op),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_color       (req_color),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_word  (rsp_pixel_word),
      .rsp_red8        (rsp_red8),
      .rsp_green8      (rsp_green8),
      .rsp_blue8       (rsp_blue8),
      .rsp_in_range    (rsp_in_range)
   );

`ifndef SYNTHESIS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_in_range) |-> (rsp_pixel_word == '0))
      else $error("out of range read returned a nonzero pixel");
`endif

endmodule
